// ----- sv/gvq_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gvq_pkg: shared types and constants of the grid value class quantizer
// Register indexes, mode codes and the structs that travel down the pipeline.
// ---------------------------------------------------------------------------
package gvq_pkg;

   localparam logic [2:0] REG_MODE      = 3'd0;
   localparam logic [2:0] REG_MIN_VALUE = 3'd1;
   localparam logic [2:0] REG_MAX_VALUE = 3'd2;
   localparam logic [2:0] REG_NUM_CLASS = 3'd3;
   localparam logic [2:0] REG_BND_COUNT = 3'd4;

   localparam logic [1:0] MODE_INTEGER  = 2'd0;
   localparam logic [1:0] MODE_LINEAR   = 2'd1;
   localparam logic [1:0] MODE_BOUNDARY = 2'd2;

   localparam logic [7:0] CLASS_LIMIT   = 8'd254;

   // Control and side results that ride along with the divider stages.
   typedef struct packed {
      logic       valid;
      logic [1:0] mode;
      logic       missing;
      logic       int_small;
      logic       int_single;
      logic [7:0] int_low;
      logic       lin_zero;
      logic       lin_cap;
      logic [7:0] cnt_m1;
      logic       bnd_draw;
      logic [7:0] bnd_class;
   } gvq_ctl_type;

   // Working state of the linear divider and the integer modulo unit.
   typedef struct packed {
      logic [31:0] lin_rem;
      logic [7:0]  lin_bits;
      logic [31:0] lin_div;
      logic [7:0]  lin_quo;
      logic [7:0]  int_rem;
      logic [15:0] int_bits;
      logic [7:0]  int_div;
   } gvq_div_type;

endpackage

// ----- sv/grid_value_class_quantizer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_value_class_quantizer: density slicing colour class quantizer
// Maps signed Q16.16 cell values to colour classes in integer, linear or
// boundary table mode; load items fill the boundary table.
// ---------------------------------------------------------------------------
// The block accepts one item every cycle unless a result stall holds it, and
// passes each classify item through an input stage, an offset and compare
// stage, a multiply and search stage, eight restoring divider stages that
// produce the linear quotient and the integer wrap modulo, and the output
// register. Load items write the table at their transfer and give no result.
// A stall on the result side holds the whole pipeline.
module grid_value_class_quantizer #(
   parameter int MAX_BOUNDARIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [3:0]         req_entry_index,
   input  logic signed [31:0] req_cell_value,
   input  logic               req_cell_missing,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_class_index,
   output logic               rsp_draw,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int IW = (MAX_BOUNDARIES > 1) ? $clog2(MAX_BOUNDARIES) : 1;
   localparam int NW = $clog2(MAX_BOUNDARIES + 1);
   localparam int NDIV = 8;

   // Configuration registers.
   logic [1:0]         mode_ff;
   logic signed [31:0] min_ff;
   logic signed [31:0] max_ff;
   logic [7:0]         ncls_ff;
   logic [4:0]         bcnt_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= gvq_pkg::MODE_LINEAR;
         min_ff  <= 32'sd0;
         max_ff  <= 32'sd65536;
         ncls_ff <= 8'd16;
         bcnt_ff <= 5'd0;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            gvq_pkg::REG_MODE:      mode_ff <= csr_pwdata[1:0];
            gvq_pkg::REG_MIN_VALUE: min_ff  <= csr_pwdata;
            gvq_pkg::REG_MAX_VALUE: max_ff  <= csr_pwdata;
            gvq_pkg::REG_NUM_CLASS: ncls_ff <= csr_pwdata[7:0];
            gvq_pkg::REG_BND_COUNT: bcnt_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         gvq_pkg::REG_MODE:      csr_prdata = {30'd0, mode_ff};
         gvq_pkg::REG_MIN_VALUE: csr_prdata = min_ff;
         gvq_pkg::REG_MAX_VALUE: csr_prdata = max_ff;
         gvq_pkg::REG_NUM_CLASS: csr_prdata = {24'd0, ncls_ff};
         gvq_pkg::REG_BND_COUNT: csr_prdata = {27'd0, bcnt_ff};
         default:                csr_prdata = 32'd0;
      endcase
   end

   // Effective class count and boundary count.
   logic [7:0]    cnt;
   logic [NW-1:0] nbnd;

   always_comb begin
      if (ncls_ff == 8'd0) begin
         cnt = 8'd1;
      end else if (ncls_ff > gvq_pkg::CLASS_LIMIT) begin
         cnt = gvq_pkg::CLASS_LIMIT;
      end else begin
         cnt = ncls_ff;
      end
      if (32'(bcnt_ff) > MAX_BOUNDARIES) begin
         nbnd = NW'(MAX_BOUNDARIES);
      end else begin
         nbnd = NW'(bcnt_ff);
      end
   end

   // Handshake: the pipeline moves unless the output register holds a stalled result.
   logic adv;
   logic req_xfer;
   logic out_valid_ff;

   assign req_stall = out_valid_ff & rsp_stall;
   assign adv = ~req_stall;
   assign req_xfer = req_valid & ~req_stall;

   // Boundary table, written by load items at their transfer.
   logic signed [31:0] tbl_ff [MAX_BOUNDARIES];

   always_ff @(posedge clock) begin
      if (req_xfer && !req_cmd && (32'(req_entry_index) < MAX_BOUNDARIES)) begin
         tbl_ff[IW'(req_entry_index)] <= req_cell_value;
      end
   end

   // Stage 0: input register.
   logic               s0_valid_ff;
   logic signed [31:0] s0_val_ff;
   logic               s0_miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_xfer & req_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_val_ff  <= req_cell_value;
         s0_miss_ff <= req_cell_missing;
      end
   end

   // Stage 1: offset, range and the parallel boundary compare.
   logic                      s1_valid_ff;
   logic                      s1_miss_ff;
   logic [1:0]                s1_mode_ff;
   logic signed [32:0]        s1_off_ff;
   logic signed [32:0]        s1_rng_ff;
   logic [MAX_BOUNDARIES-1:0] s1_gt_ff;
   logic                      s1_ge0_ff;
   logic [MAX_BOUNDARIES-1:0] gt_in;

   always_comb begin
      for (int i = 0; i < MAX_BOUNDARIES; i++) begin
         gt_in[i] = (s0_val_ff > tbl_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_miss_ff <= s0_miss_ff;
         s1_mode_ff <= mode_ff;
         s1_off_ff  <= 33'(s0_val_ff) - 33'(min_ff);
         s1_rng_ff  <= 33'(max_ff) - 33'(min_ff);
         s1_gt_ff   <= gt_in;
         s1_ge0_ff  <= (s0_val_ff >= tbl_ff[0]);
      end
   end

   // Stage 2: class flags, the count multiply and the first-match search.
   gvq_pkg::gvq_ctl_type s2_ctl_in;
   gvq_pkg::gvq_div_type s2_div_in;
   gvq_pkg::gvq_ctl_type ctl_ff [NDIV+1];
   gvq_pkg::gvq_div_type div_ff [NDIV+1];
   logic [15:0]          icls;
   logic [31:0]          offp;
   logic [39:0]          num;
   logic                 found;
   logic [IW-1:0]        hit;

   always_comb begin
      offp = s1_off_ff[31:0];
      icls = s1_off_ff[32] ? 16'd0 : offp[31:16];
      num  = 40'(cnt) * 40'(offp);
      found = 1'b0;
      hit = '0;
      for (int i = MAX_BOUNDARIES - 1; i >= 0; i--) begin
         if (!s1_gt_ff[i] && (i < 32'(nbnd))) begin
            found = 1'b1;
            hit = IW'(i);
         end
      end

      s2_ctl_in.valid      = s1_valid_ff;
      s2_ctl_in.mode       = s1_mode_ff;
      s2_ctl_in.missing    = s1_miss_ff;
      s2_ctl_in.int_small  = (icls < {8'd0, cnt});
      s2_ctl_in.int_single = (cnt == 8'd1);
      s2_ctl_in.int_low    = icls[7:0];
      s2_ctl_in.lin_zero   = s1_off_ff[32] || (s1_off_ff == 33'sd0) ||
                             s1_rng_ff[32] || (s1_rng_ff == 33'sd0);
      s2_ctl_in.lin_cap    = (offp >= s1_rng_ff[31:0]);
      s2_ctl_in.cnt_m1     = cnt - 8'd1;
      s2_ctl_in.bnd_draw   = (32'(nbnd) >= 2) && s1_ge0_ff && found;
      s2_ctl_in.bnd_class  = (hit == '0) ? 8'd0 : 8'(hit - IW'(1));

      // Since the offset stays below the range here, cnt * offset >> 8 is
      // below the range and the quotient fits eight bits.
      s2_div_in.lin_rem  = num[39:8];
      s2_div_in.lin_bits = num[7:0];
      s2_div_in.lin_div  = s1_rng_ff[31:0];
      s2_div_in.lin_quo  = 8'd0;
      s2_div_in.int_rem  = 8'd0;
      s2_div_in.int_bits = icls;
      s2_div_in.int_div  = cnt - 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0].valid <= 1'b0;
      end else if (adv) begin
         ctl_ff[0] <= s2_ctl_in;
         div_ff[0] <= s2_div_in;
      end
   end

   // Divider stages.
   for (genvar g = 0; g < NDIV; g++) begin : g_div
      gvq_div_stage u_stage (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .ctl_in (ctl_ff[g]),
         .div_in (div_ff[g]),
         .ctl_ff (ctl_ff[g+1]),
         .div_ff (div_ff[g+1])
      );
   end

   // Output stage: pick the result of the active mode.
   gvq_pkg::gvq_ctl_type fc;
   gvq_pkg::gvq_div_type fd;
   logic [7:0]           cls_in;
   logic                 draw_in;
   logic [7:0]           cls_ff;
   logic                 draw_ff;

   assign fc = ctl_ff[NDIV];
   assign fd = div_ff[NDIV];

   always_comb begin
      cls_in = 8'd0;
      draw_in = 1'b0;
      if (!fc.missing) begin
         case (fc.mode)
            gvq_pkg::MODE_INTEGER: begin
               draw_in = 1'b1;
               if (fc.int_small) begin
                  cls_in = fc.int_low;
               end else if (fc.int_single) begin
                  cls_in = 8'd0;
               end else begin
                  cls_in = fd.int_rem;
               end
            end
            gvq_pkg::MODE_LINEAR: begin
               draw_in = 1'b1;
               if (fc.lin_zero) begin
                  cls_in = 8'd0;
               end else if (fc.lin_cap || (fd.lin_quo > fc.cnt_m1)) begin
                  cls_in = fc.cnt_m1;
               end else begin
                  cls_in = fd.lin_quo;
               end
            end
            gvq_pkg::MODE_BOUNDARY: begin
               draw_in = fc.bnd_draw;
               cls_in = fc.bnd_draw ? fc.bnd_class : 8'd0;
            end
            default: begin
               draw_in = 1'b0;
               cls_in = 8'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= fc.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cls_ff  <= cls_in;
         draw_ff <= draw_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_class_index = cls_ff;
   assign rsp_draw = draw_ff;

`ifndef SYNTHESIS
   a_nodraw_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_draw) |-> (rsp_class_index == 8'd0))
      else $error("undrawn result carries a nonzero class");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && rsp_stall))
      else $error("input stalled without a waiting result");

   a_linear_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (mode_ff == gvq_pkg::MODE_LINEAR)) |->
      (rsp_class_index <= cnt - 8'd1))
      else $error("linear class beyond the class count");
`endif

endmodule

// ----- sv/gvq_div_stage.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gvq_div_stage: one register stage of the shared division pipeline
// Performs one restoring step of the linear quotient and two restoring
// steps of the integer class modulo.
// ---------------------------------------------------------------------------
module gvq_div_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  gvq_pkg::gvq_ctl_type ctl_in,
   input  gvq_pkg::gvq_div_type div_in,
   output gvq_pkg::gvq_ctl_type ctl_ff,
   output gvq_pkg::gvq_div_type div_ff
);

   gvq_pkg::gvq_div_type div_in_next;
   logic [32:0] lin_t;
   logic [8:0]  int_t0;
   logic [8:0]  int_t1;
   logic [7:0]  int_r0;
   logic        lin_bit;

   always_comb begin
      div_in_next = div_in;
      lin_t = {div_in.lin_rem, div_in.lin_bits[7]};
      lin_bit = (lin_t >= {1'b0, div_in.lin_div});
      if (lin_bit) begin
         div_in_next.lin_rem = 32'(lin_t - {1'b0, div_in.lin_div});
      end else begin
         div_in_next.lin_rem = lin_t[31:0];
      end
      div_in_next.lin_bits = {div_in.lin_bits[6:0], 1'b0};
      div_in_next.lin_quo = {div_in.lin_quo[6:0], lin_bit};

      int_t0 = {div_in.int_rem, div_in.int_bits[15]};
      if (int_t0 >= {1'b0, div_in.int_div}) begin
         int_r0 = 8'(int_t0 - {1'b0, div_in.int_div});
      end else begin
         int_r0 = int_t0[7:0];
      end
      int_t1 = {int_r0, div_in.int_bits[14]};
      if (int_t1 >= {1'b0, div_in.int_div}) begin
         div_in_next.int_rem = 8'(int_t1 - {1'b0, div_in.int_div});
      end else begin
         div_in_next.int_rem = int_t1[7:0];
      end
      div_in_next.int_bits = {div_in.int_bits[13:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
         div_ff <= div_in_next;
      end
   end

endmodule
